/* rtl/core/dual_windowed_mean_core_defines.svh */
// assertion macros for the dual windowed mean core checker
// no dependencies; included by files that hold concurrent assertions
`ifndef DUAL_WINDOWED_MEAN_CORE_DEFINES_SVH
`define DUAL_WINDOWED_MEAN_CORE_DEFINES_SVH

// property checked only while reset is released
`define DWM_ASSERT_RUN(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("dwm check failed");

// property checked at every edge, reset included
`define DWM_ASSERT_ALL(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("dwm check failed during reset");

`endif

/* rtl/core/dwm_pkg.sv */
// shared widths, window sizes and status types of the dual windowed mean core
// no dependencies
package dwm_pkg;

	localparam int VAL_W     = 16;
	localparam int MEAN_W    = 16;
	localparam int SUM_W     = 20;
	localparam int HR_WINDOW = 10;
	localparam int OX_WINDOW = 10;

	// ring depth covers the larger window; narrower channel leaves top slots unused
	localparam int RING_DEPTH = (HR_WINDOW > OX_WINDOW) ? HR_WINDOW : OX_WINDOW;
	localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [MEAN_W-1:0]       mean_t;
	typedef logic [FILL_W-1:0]       fill_t;

	// per-channel control from the sequencer
	typedef struct packed {
		logic start;
		logic push;
	} chan_ctl_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// channel status back to the sequencer
	typedef struct packed {
		logic done;
	} chan_stat_t;

endpackage

/* rtl/core/dual_windowed_mean_core.sv */
// Dual windowed mean core: two moving-average channels (heart rate and oxygen
// saturation) with windows of HR_WINDOW and OX_WINDOW samples. Each accepted
// sample word produces one result word holding both absolute truncated means; a
// channel whose valid flag is clear keeps its previous mean. From acceptance to
// result: the ring and sum update at acceptance, a register starts the divider,
// the bit-serial restoring divider that both channels run side by side produces
// SUM_W quotient bits, and the output register loads. The result sits in an output
// register, so the next sample is taken while a result still waits; a new sample
// is taken only once the previous result has been loaded. Rings clear at reset.
// depends on dwm_pkg, dwm_chan
module dual_windowed_mean_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  dwm_pkg::value_t   hr_value,
	input  logic              hr_valid,
	input  dwm_pkg::value_t   ox_value,
	input  logic              ox_valid,
	output logic              result_valid,
	input  logic              result_stall,
	output dwm_pkg::mean_t    hr_mean,
	output dwm_pkg::mean_t    ox_mean
);
	import dwm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	mean_t      hr_mean_q;
	mean_t      ox_mean_q;
	logic       accept;
	logic       done;
	logic       out_free;
	logic       load;
	chan_ctl_t  hr_ctl;
	chan_ctl_t  ox_ctl;
	chan_stat_t hr_stat;
	chan_stat_t ox_stat;
	mean_t      hr_held;
	mean_t      ox_held;

	// handshake and result register load
	always_comb begin
		sample_stall = (state_q != ST_IDLE);
		accept       = sample_valid && !sample_stall;
		done         = hr_stat.done && ox_stat.done;
		out_free     = !out_valid_q || !result_stall;
		load         = out_free && (((state_q == ST_RUN) && done) || (state_q == ST_HOLD));
		hr_ctl.start = accept;
		hr_ctl.push  = hr_valid;
		ox_ctl.start = accept;
		ox_ctl.push  = ox_valid;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (done) state_q <= out_free ? ST_IDLE : ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hr_mean_q <= hr_held;
			ox_mean_q <= ox_held;
		end
	end

	dwm_chan u_hr (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hr_ctl),
		.value     (hr_value),
		.window    (FILL_W'(HR_WINDOW)),
		.held_mean (hr_held),
		.stat      (hr_stat)
	);

	dwm_chan u_ox (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ox_ctl),
		.value     (ox_value),
		.window    (FILL_W'(OX_WINDOW)),
		.held_mean (ox_held),
		.stat      (ox_stat)
	);

	assign result_valid = out_valid_q;
	assign hr_mean      = hr_mean_q;
	assign ox_mean      = ox_mean_q;

endmodule

/* rtl/core/dwm_div.sv */
// bit-serial restoring divider: unsigned sum by fill count, one quotient bit a cycle
// depends on dwm_pkg
module dwm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [dwm_pkg::SUM_W-1:0]           dividend,
	input  dwm_pkg::fill_t                      divisor,
	output logic [dwm_pkg::SUM_W-1:0]           quotient,
	output dwm_pkg::div_stat_t                  stat
);
	import dwm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     num_q;
	logic [FILL_W-1:0]    rem_q;
	logic [FILL_W-1:0]    den_q;
	logic [FILL_W:0]      trial;
	logic [FILL_W:0]      diff;
	logic                 qbit;

	// one restoring step: bring down the next dividend bit and try the divisor
	always_comb begin
		trial = {rem_q, num_q[SUM_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	// control: counts the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/core/dwm_chan.sv */
// one moving-average channel: ring, running sum, slot and fill, serial mean
// depends on dwm_pkg and dwm_div
module dwm_chan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dwm_pkg::chan_ctl_t   ctl,
	input  dwm_pkg::value_t      value,
	input  dwm_pkg::fill_t       window,
	output dwm_pkg::mean_t       held_mean,
	output dwm_pkg::chan_stat_t  stat
);
	import dwm_pkg::*;

	value_t                   ring_q [RING_DEPTH];
	logic signed [SUM_W-1:0]  total_q;
	logic [SLOT_W-1:0]        slot_q;
	fill_t                    fill_q;
	logic                     push_q;
	logic                     load_s1;
	mean_t                    held_q;

	logic signed [SUM_W-1:0]  old_ext;
	logic signed [SUM_W-1:0]  new_ext;
	fill_t                    slot_inc;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W-1:0]         quot;
	div_stat_t                div_stat;

	// sign-extend the leaving and entering values, next slot
	always_comb begin
		old_ext  = {{(SUM_W-VAL_W){ring_q[slot_q][VAL_W-1]}}, ring_q[slot_q]};
		new_ext  = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
		slot_inc = FILL_W'(slot_q) + 1'b1;
	end

	// ring and running sum update on a pushed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			total_q <= '0;
			slot_q  <= '0;
			fill_q  <= '0;
			push_q  <= 1'b0;
			load_s1 <= 1'b0;
			held_q  <= '0;
		end else begin
			load_s1 <= ctl.start;
			if (ctl.start) begin
				push_q <= ctl.push;
				if (ctl.push) begin
					total_q        <= total_q - old_ext + new_ext;
					ring_q[slot_q] <= value;
					slot_q         <= (slot_inc >= window) ? '0 : slot_inc[SLOT_W-1:0];
					if (fill_q < window) begin
						fill_q <= fill_q + 1'b1;
					end
				end
			end
			// keep the previous mean unless this word was pushed
			if (div_stat.done && push_q) begin
				held_q <= quot[MEAN_W-1:0];
			end
		end
	end

	// magnitude of the sum; dividing it truncates toward zero
	assign mag = total_q[SUM_W-1] ? (~total_q + 1'b1) : total_q;

	dwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (load_s1),
		.dividend (mag),
		.divisor  (fill_q),
		.quotient (quot),
		.stat     (div_stat)
	);

	// fresh mean passes straight through in the divider's done cycle
	assign held_mean = (div_stat.done && push_q) ? quot[MEAN_W-1:0] : held_q;
	assign stat.done = div_stat.done;

endmodule

/* rtl/core/dwm_checker.sv */
// port-level checks of the dual windowed mean core, bound to the top level
// depends on dwm_pkg and dual_windowed_mean_core_defines.svh
`include "dual_windowed_mean_core_defines.svh"

module dwm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            sample_valid,
	input logic            sample_stall,
	input dwm_pkg::value_t hr_value,
	input logic            hr_valid,
	input dwm_pkg::value_t ox_value,
	input logic            ox_valid,
	input logic            result_valid,
	input logic            result_stall,
	input dwm_pkg::mean_t  hr_mean,
	input dwm_pkg::mean_t  ox_mean
);
	import dwm_pkg::*;

	// a stalled result word holds
	`DWM_ASSERT_RUN(a_result_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(hr_mean) && $stable(ox_mean))

	// the core is busy right after it takes a sample
	`DWM_ASSERT_RUN(a_busy_after_accept, clk, arst_n, sample_valid && !sample_stall |=> sample_stall)

	// a mean magnitude never exceeds the largest possible sample magnitude, 16'h8000
	`DWM_ASSERT_RUN(a_mean_bound, clk, arst_n, result_valid |-> (hr_mean <= 16'h8000) && (ox_mean <= 16'h8000))

	// reset empties the result register: no result word follows a sampled reset
	`DWM_ASSERT_ALL(a_reset_empty, clk, !arst_n |=> !result_valid)

endmodule

bind dual_windowed_mean_core dwm_checker u_dwm_checker (.*);
